### hdl/ifbas_pkg.sv
// Package for the IMU frame averager: sizes, sample frame type, sequencer states
// and the gyro scaling constants. No dependencies.
`timescale 1ns / 1ps

package ifbas_pkg;

    localparam int AXES        = 3;
    localparam int NCH         = 2 * AXES;
    localparam int SAMPLE_W    = 16;

    localparam int AVG_SHIFT   = 3;
    localparam int AVG_DEPTH   = 1 << AVG_SHIFT;
    localparam int SUM_W       = SAMPLE_W + AVG_SHIFT;

    localparam int CAL_SHIFT   = 5;
    localparam int CAL_FRAMES  = 1 << CAL_SHIFT;
    localparam int CAL_CNT_W   = CAL_SHIFT + 1;
    localparam int BACC_W      = SAMPLE_W + CAL_SHIFT;

    localparam int ACCEL_SHIFT = 14;
    localparam int ACCEL_W     = 2;

    localparam int GYRO_NUM    = 10;
    localparam int GYRO_DEN    = 328;
    localparam int DIV_BITS    = 10;
    localparam int MAG_W       = SAMPLE_W + 1;
    localparam int DPS_W       = DIV_BITS + 1;

    // Times ten over 328 is times five over 164. The reciprocal is rounded up so
    // that the top bits of the product give the exact floor for every magnitude
    // up to 32768.
    localparam int RECIP_SHIFT = 25;
    localparam int RECIP_W     = 20;
    localparam int GYRO_RECIP  = (((1 << RECIP_SHIFT) + (GYRO_DEN / 2) - 1) / (GYRO_DEN / 2))
                               * (GYRO_NUM / 2);
    localparam int PROD_W      = MAG_W + RECIP_W;

    localparam int CNT_W       = AVG_SHIFT;

    typedef logic [NCH-1:0][SAMPLE_W-1:0] frame_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_PREP,
        S_DONE
    } state_t;

endpackage

### hdl/imu_frame_average_bias_scale.sv
// Top level of the IMU frame averager with gyro bias calibration and scaling.
// Depends on ifbas_pkg, ifbas_cell and ifbas_gyro_div.
// One item is in work at a time: it is accepted in S_IDLE, the history chain rotates
// in S_SUM to form the sums, S_PREP does the bias step and loads the scaler, and S_DONE
// registers the result, waiting there while the output is stalled.
// Reset (synchronous, active low) clears the history, calibration state and bias.
`timescale 1ns / 1ps

module imu_frame_average_bias_scale
    import ifbas_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_accel_x_raw,
    input  logic signed [SAMPLE_W-1:0] s_accel_y_raw,
    input  logic signed [SAMPLE_W-1:0] s_accel_z_raw,
    input  logic signed [SAMPLE_W-1:0] s_gyro_x_raw,
    input  logic signed [SAMPLE_W-1:0] s_gyro_y_raw,
    input  logic signed [SAMPLE_W-1:0] s_gyro_z_raw,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [ACCEL_W-1:0]  m_accel_x_g,
    output logic signed [ACCEL_W-1:0]  m_accel_y_g,
    output logic signed [ACCEL_W-1:0]  m_accel_z_g,
    output logic signed [DPS_W-1:0]    m_gyro_x_dps,
    output logic signed [DPS_W-1:0]    m_gyro_y_dps,
    output logic signed [DPS_W-1:0]    m_gyro_z_dps,
    output logic                       m_calibrating
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic accept;
    logic shift_en;
    logic out_free;
    logic cal;

    frame_t in_frame;
    frame_t head_din;
    frame_t chain [AVG_DEPTH];
    frame_t tail;

    logic signed [SUM_W-1:0]    sum_reg [NCH];
    logic signed [BACC_W-1:0]   bacc_reg [AXES];
    logic signed [BACC_W-1:0]   bacc_next [AXES];
    logic signed [SAMPLE_W-1:0] bias_reg [AXES];
    logic [CAL_CNT_W-1:0]       cal_cnt_reg;
    logic                       calib_reg;
    logic [ACCEL_W-1:0]         accel_reg [AXES];
    logic [ACCEL_W-1:0]         accel_next [AXES];

    logic signed [SAMPLE_W-1:0] gyr_avg [AXES];
    logic signed [SAMPLE_W-1:0] gyr_sat [AXES];
    logic signed [DPS_W-1:0]    dps [AXES];
    logic                       div_load;

    logic                       m_valid_reg;
    logic [ACCEL_W-1:0]         m_accel_reg [AXES];
    logic [DPS_W-1:0]           m_dps_reg [AXES];
    logic                       m_calib_reg;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign shift_en = accept || (state_reg == S_SUM);
    assign out_free = !m_valid_reg || m_ready;
    assign cal      = (cal_cnt_reg < CAL_CNT_W'(CAL_FRAMES));

    assign in_frame = {s_gyro_z_raw, s_gyro_y_raw, s_gyro_x_raw,
                       s_accel_z_raw, s_accel_y_raw, s_accel_x_raw};
    assign tail     = chain[AVG_DEPTH-1];
    assign head_din = accept ? in_frame : tail;

    // The history chain shifts a new frame in on accept, then rotates once
    // around per frame so that each cell passes the tail for summing.
    ifbas_cell u_cell_head (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (shift_en),
        .din      (head_din),
        .dout     (chain[0])
    );

    for (genvar k = 1; k < AVG_DEPTH; k++) begin : g_cell
        ifbas_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .din      (chain[k-1]),
            .dout     (chain[k])
        );
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        div_load   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SUM;
                    cnt_next   = '0;
                end
            end
            S_SUM: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(AVG_DEPTH - 1)) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                div_load   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            logic signed [SAMPLE_W-1:0] acc_avg;
            logic signed [SAMPLE_W:0]   acc_adj;
            logic signed [SAMPLE_W-1:0] bias_sel;
            logic signed [SAMPLE_W:0]   diff;
            acc_avg  = sum_reg[a][SUM_W-1:AVG_SHIFT];
            acc_adj  = {acc_avg[SAMPLE_W-1], acc_avg}
                     + (acc_avg[SAMPLE_W-1] ? (SAMPLE_W+1)'((1 << ACCEL_SHIFT) - 1)
                                            : (SAMPLE_W+1)'(0));
            accel_next[a] = acc_adj[ACCEL_SHIFT+ACCEL_W-1:ACCEL_SHIFT];

            gyr_avg[a] = sum_reg[AXES+a][SUM_W-1:AVG_SHIFT];
            bias_sel   = cal ? SAMPLE_W'(0) : bias_reg[a];
            diff       = {gyr_avg[a][SAMPLE_W-1], gyr_avg[a]}
                       - {bias_sel[SAMPLE_W-1], bias_sel};
            if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
                gyr_sat[a] = diff[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                            : {1'b0, {(SAMPLE_W-1){1'b1}}};
            end else begin
                gyr_sat[a] = diff[SAMPLE_W-1:0];
            end
            bacc_next[a] = bacc_reg[a] + BACC_W'(gyr_avg[a]);
        end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_div
        ifbas_gyro_div u_div (
            .aclk (aclk),
            .load (div_load),
            .diff (gyr_sat[a]),
            .dps  (dps[a])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            cal_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                bacc_reg[a] <= '0;
                bias_reg[a] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_PREP && cal) begin
                cal_cnt_reg <= cal_cnt_reg + CAL_CNT_W'(1);
                for (int a = 0; a < AXES; a++) begin
                    bacc_reg[a] <= bacc_next[a];
                    if (cal_cnt_reg == CAL_CNT_W'(CAL_FRAMES - 1)) begin
                        bias_reg[a] <= bacc_next[a][BACC_W-1:CAL_SHIFT];
                    end
                end
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < NCH; c++) begin
            if (accept) begin
                sum_reg[c] <= '0;
            end else if (state_reg == S_SUM) begin
                sum_reg[c] <= sum_reg[c] + SUM_W'($signed(tail[c]));
            end
        end
        if (state_reg == S_PREP) begin
            calib_reg <= cal;
            for (int a = 0; a < AXES; a++) begin
                accel_reg[a] <= accel_next[a];
            end
        end
        if (state_reg == S_DONE && out_free) begin
            m_calib_reg <= calib_reg;
            for (int a = 0; a < AXES; a++) begin
                m_accel_reg[a] <= accel_reg[a];
                m_dps_reg[a]   <= dps[a];
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accel_x_g   = m_accel_reg[0];
    assign m_accel_y_g   = m_accel_reg[1];
    assign m_accel_z_g   = m_accel_reg[2];
    assign m_gyro_x_dps  = m_dps_reg[0];
    assign m_gyro_y_dps  = m_dps_reg[1];
    assign m_gyro_z_dps  = m_dps_reg[2];
    assign m_calibrating = m_calib_reg;

endmodule

### hdl/ifbas_cell.sv
// One cell of the sample history chain: holds one frame of six samples.
// Depends on ifbas_pkg.
`timescale 1ns / 1ps

module ifbas_cell
    import ifbas_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   shift_en,
    input  frame_t din,
    output frame_t dout
);

    frame_t q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else if (shift_en) begin
            q_reg <= din;
        end
    end

    assign dout = q_reg;

endmodule

### hdl/ifbas_gyro_div.sv
// Gyro rate scaler for one axis: magnitude times ten over 328 by a constant
// reciprocal multiplication, with the sign restored. Depends on ifbas_pkg.
`timescale 1ns / 1ps

module ifbas_gyro_div
    import ifbas_pkg::*;
(
    input  logic                       aclk,
    input  logic                       load,
    input  logic signed [SAMPLE_W-1:0] diff,
    output logic signed [DPS_W-1:0]    dps
);

    logic                neg_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic [MAG_W-1:0]    mag;
    logic [PROD_W-1:0]   prod;
    logic [DIV_BITS-1:0] quo;

    assign mag = diff[SAMPLE_W-1] ? (MAG_W'(0) - {1'b1, diff}) : {1'b0, diff};

    always_ff @(posedge aclk) begin
        if (load) begin
            neg_reg <= diff[SAMPLE_W-1];
            mag_reg <= mag;
        end
    end

    assign prod = PROD_W'(mag_reg) * PROD_W'(GYRO_RECIP);
    assign quo  = prod[RECIP_SHIFT+DIV_BITS-1:RECIP_SHIFT];
    assign dps  = neg_reg ? (DPS_W'(0) - {1'b0, quo}) : {1'b0, quo};

endmodule

### hdl/ifbas_checker.sv
// Port-level checker for imu_frame_average_bias_scale, bound to the top level.
// Depends on ifbas_pkg.
`timescale 1ns / 1ps

module ifbas_checker
    import ifbas_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [ACCEL_W-1:0]  m_accel_x_g,
    input logic signed [DPS_W-1:0]    m_gyro_x_dps,
    input logic signed [DPS_W-1:0]    m_gyro_y_dps,
    input logic signed [DPS_W-1:0]    m_gyro_z_dps,
    input logic                       m_calibrating
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped before it was taken");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_gyro_x_dps) && $stable(m_accel_x_g)
                                && $stable(m_calibrating))
        else $error("stalled result changed");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear the output or busy state");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("a second item was taken while one is in work");

    a_dps_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_gyro_x_dps >= -999 && m_gyro_x_dps <= 999
                 && m_gyro_y_dps >= -999 && m_gyro_y_dps <= 999
                 && m_gyro_z_dps >= -999 && m_gyro_z_dps <= 999)
        else $error("gyro rate out of range");

endmodule

bind imu_frame_average_bias_scale ifbas_checker u_ifbas_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_accel_x_g   (m_accel_x_g),
    .m_gyro_x_dps  (m_gyro_x_dps),
    .m_gyro_y_dps  (m_gyro_y_dps),
    .m_gyro_z_dps  (m_gyro_z_dps),
    .m_calibrating (m_calibrating)
);
